/* rtl/cpsw_pkg.sv */
`timescale 1ns / 1ps

package cpsw_pkg;

   // largest accepted indirect buffer size is one below this
   localparam logic [31:0] INDIRECT_SIZE_LIMIT = 32'd262144;

   localparam logic [1:0]  PKT_TYPE2         = 2'd2;
   localparam logic [1:0]  PKT_TYPE3         = 2'd3;
   localparam logic [6:0]  OPC_INTERRUPT     = 7'h40;
   localparam logic [6:0]  OPC_INDIRECT      = 7'h3F;
   localparam logic [15:0] REG_SCRATCH_FIRST = 16'h0578;
   localparam logic [15:0] REG_SCRATCH_LAST  = 16'h057F;
   localparam logic [15:0] REG_WB_CTRL_LO    = 16'h01DC;
   localparam logic [15:0] REG_WB_CTRL_HI    = 16'h01DD;

   typedef enum logic [2:0] {
      KIND_PAD     = 3'd0,
      KIND_REG_HDR = 3'd1,
      KIND_CMD_HDR = 3'd2,
      KIND_REG_PAY = 3'd3,
      KIND_CMD_PAY = 3'd4
   } word_kind_type;

   typedef struct packed {
      word_kind_type word_kind;
      logic [1:0]    packet_type;
      logic [6:0]    command_opcode;
      logic [15:0]   register_number;
      logic [13:0]   payload_index;
      logic          watch_hit;
      logic          scratch_write;
      logic          writeback_control_write;
      logic          interrupt_header;
      logic          indirect_valid;
      logic [31:0]   indirect_address;
      logic [17:0]   indirect_size;
   } result_type;

endpackage

/* rtl/cpsw_req_if.sv */
`timescale 1ns / 1ps

interface cpsw_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] stream_word;
   logic        buffer_end;

   modport source (output valid, output stream_word, output buffer_end, input ready);
   modport sink   (input valid, input stream_word, input buffer_end, output ready);
endinterface

/* rtl/cpsw_rsp_if.sv */
`timescale 1ns / 1ps

interface cpsw_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  word_kind;
   logic [1:0]  packet_type;
   logic [6:0]  command_opcode;
   logic [15:0] register_number;
   logic [13:0] payload_index;
   logic        watch_hit;
   logic        scratch_write;
   logic        writeback_control_write;
   logic        interrupt_header;
   logic        indirect_valid;
   logic [31:0] indirect_address;
   logic [17:0] indirect_size;

   modport source (
      output valid, output word_kind, output packet_type, output command_opcode,
      output register_number, output payload_index, output watch_hit,
      output scratch_write, output writeback_control_write, output interrupt_header,
      output indirect_valid, output indirect_address, output indirect_size,
      input ready
   );
   modport sink (
      input valid, input word_kind, input packet_type, input command_opcode,
      input register_number, input payload_index, input watch_hit,
      input scratch_write, input writeback_control_write, input interrupt_header,
      input indirect_valid, input indirect_address, input indirect_size,
      output ready
   );
endinterface

/* rtl/cpsw_parser.sv */
`timescale 1ns / 1ps

module cpsw_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [31:0]          word,
   input  logic                 last,
   input  logic [28:0]          watch_offset,
   output cpsw_pkg::result_type result
);

   logic [14:0] words_left_ff, words_left_in;
   logic [13:0] position_ff, position_in;
   logic [1:0]  type_ff, type_in;
   logic [6:0]  opcode_ff, opcode_in;
   logic [14:0] first_reg_ff, first_reg_in;
   logic        hit_seen_ff, hit_seen_in;
   logic [31:0] held_addr_ff, held_addr_in;

   logic [15:0] reg_num;
   logic        match;

   always_comb begin
      result        = '0;
      words_left_in = words_left_ff;
      position_in   = position_ff;
      type_in       = type_ff;
      opcode_in     = opcode_ff;
      first_reg_in  = first_reg_ff;
      hit_seen_in   = hit_seen_ff;
      held_addr_in  = held_addr_ff;
      match         = (word[28:0] == watch_offset);
      reg_num       = {1'b0, first_reg_ff} + {2'b0, position_ff};

      if (words_left_ff == '0) begin
         result.packet_type = word[31:30];
         if (word != '0 && word[31:30] != cpsw_pkg::PKT_TYPE2) begin
            words_left_in = {1'b0, word[29:16]} + 15'd1;
            position_in   = '0;
            type_in       = word[31:30];
            hit_seen_in   = 1'b0;
            held_addr_in  = '0;
            if (word[31:30] == cpsw_pkg::PKT_TYPE3) begin
               opcode_in               = word[14:8];
               first_reg_in            = '0;
               result.word_kind        = cpsw_pkg::KIND_CMD_HDR;
               result.command_opcode   = word[14:8];
               result.interrupt_header = (word[14:8] == cpsw_pkg::OPC_INTERRUPT);
            end else begin
               first_reg_in     = word[14:0];
               opcode_in        = '0;
               result.word_kind = cpsw_pkg::KIND_REG_HDR;
            end
         end
      end else begin
         result.packet_type   = type_ff;
         result.payload_index = position_ff;
         if (type_ff == cpsw_pkg::PKT_TYPE3) begin
            result.word_kind      = cpsw_pkg::KIND_CMD_PAY;
            result.command_opcode = opcode_ff;
            // only the first match inside a command packet counts
            if (match && !hit_seen_ff) begin
               result.watch_hit = 1'b1;
               hit_seen_in      = 1'b1;
            end
            if (position_ff == 14'd0) begin
               held_addr_in = word;
            end else if (position_ff == 14'd1 && opcode_ff == cpsw_pkg::OPC_INDIRECT) begin
               if (held_addr_ff != '0 && word != '0 &&
                   word < cpsw_pkg::INDIRECT_SIZE_LIMIT) begin
                  result.indirect_valid   = 1'b1;
                  result.indirect_address = held_addr_ff;
                  result.indirect_size    = word[17:0];
               end
            end
         end else begin
            result.word_kind       = cpsw_pkg::KIND_REG_PAY;
            result.register_number = reg_num;
            result.watch_hit       = match;
            result.scratch_write   = reg_num inside
               {[cpsw_pkg::REG_SCRATCH_FIRST:cpsw_pkg::REG_SCRATCH_LAST]};
            result.writeback_control_write = (reg_num == cpsw_pkg::REG_WB_CTRL_LO) ||
                                             (reg_num == cpsw_pkg::REG_WB_CTRL_HI);
         end
         position_in   = position_ff + 14'd1;
         words_left_in = words_left_ff - 15'd1;
      end

      // end of buffer drops whatever packet is open
      if (last) begin
         words_left_in = '0;
         position_in   = '0;
         type_in       = '0;
         opcode_in     = '0;
         first_reg_in  = '0;
         hit_seen_in   = 1'b0;
         held_addr_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_left_ff <= '0;
         position_ff   <= '0;
         type_ff       <= '0;
         opcode_ff     <= '0;
         first_reg_ff  <= '0;
         hit_seen_ff   <= 1'b0;
         held_addr_ff  <= '0;
      end else if (step) begin
         words_left_ff <= words_left_in;
         position_ff   <= position_in;
         type_ff       <= type_in;
         opcode_ff     <= opcode_in;
         first_reg_ff  <= first_reg_in;
         hit_seen_ff   <= hit_seen_in;
         held_addr_ff  <= held_addr_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step && last |=> words_left_ff == '0 && position_ff == '0)
      else $error("packet state not cleared after buffer end");

   a_indirect_pos: assert property (@(posedge clock) disable iff (reset)
      result.indirect_valid |-> result.word_kind == cpsw_pkg::KIND_CMD_PAY &&
                                result.payload_index == 14'd1)
      else $error("indirect reference outside second command payload word");

   a_reg_flags: assert property (@(posedge clock) disable iff (reset)
      (result.scratch_write || result.writeback_control_write) |->
         result.word_kind == cpsw_pkg::KIND_REG_PAY &&
         !(result.scratch_write && result.writeback_control_write))
      else $error("register flags on wrong word");

   a_cmd_hit_once: assert property (@(posedge clock) disable iff (reset)
      step && hit_seen_ff && words_left_ff != '0 && type_ff == cpsw_pkg::PKT_TYPE3
         |-> !result.watch_hit)
      else $error("second watch hit in one command packet");

endmodule

/* rtl/command_packet_stream_watch.sv */
`timescale 1ns / 1ps
// Channel  Dir  Payload                                        Transfer
// req_ch   in   stream_word[31:0], buffer_end                  valid & ready
// rsp_ch   out  word_kind .. indirect_size (one per request)   valid & ready
// csr      in   csr_write_data[28:0] = watch offset            csr_write_enable
//
// One word per cycle sustained while responses are accepted; the input register loads at the
// request transfer and the result register, which drives response valid, when the word advances.
// The decode and the packet state update sit between those two registers.
// Reset is synchronous and clears packet state, the watch offset and both valids.
// A stalled response holds its register; requests keep flowing until both stages fill.

module command_packet_stream_watch (
   input  logic              clock,
   input  logic              reset,
   cpsw_req_if.sink          req_ch,
   cpsw_rsp_if.source        rsp_ch,
   input  logic              csr_write_enable,
   input  logic [28:0]       csr_write_data
);

   logic                 in_valid_ff;
   logic [31:0]          in_word_ff;
   logic                 in_last_ff;
   logic                 out_valid_ff;
   cpsw_pkg::result_type out_ff;
   cpsw_pkg::result_type result;
   logic [28:0]          watch_offset_ff;
   logic                 advance;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         watch_offset_ff <= '0;
      end else if (csr_write_enable) begin
         watch_offset_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_word_ff <= req_ch.stream_word;
         in_last_ff <= req_ch.buffer_end;
      end
   end

   cpsw_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .word         (in_word_ff),
      .last         (in_last_ff),
      .watch_offset (watch_offset_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid                   = out_valid_ff;
   assign rsp_ch.word_kind               = out_ff.word_kind;
   assign rsp_ch.packet_type             = out_ff.packet_type;
   assign rsp_ch.command_opcode          = out_ff.command_opcode;
   assign rsp_ch.register_number         = out_ff.register_number;
   assign rsp_ch.payload_index           = out_ff.payload_index;
   assign rsp_ch.watch_hit               = out_ff.watch_hit;
   assign rsp_ch.scratch_write           = out_ff.scratch_write;
   assign rsp_ch.writeback_control_write = out_ff.writeback_control_write;
   assign rsp_ch.interrupt_header        = out_ff.interrupt_header;
   assign rsp_ch.indirect_valid          = out_ff.indirect_valid;
   assign rsp_ch.indirect_address        = out_ff.indirect_address;
   assign rsp_ch.indirect_size           = out_ff.indirect_size;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |=> out_valid_ff && $stable(out_ff))
      else $error("response changed while stalled");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_word_ff))
      else $error("input register overwritten");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result lost after decode");

endmodule

/* tb/sv/tb_command_packet_stream_watch.sv */
`timescale 1ns / 1ps

module tb_command_packet_stream_watch;

   localparam logic [1:0] PKT_TYPE0 = 2'd0;
   localparam logic [1:0] PKT_TYPE1 = 2'd1;
   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned HoldCycles = 300;
   localparam int unsigned DirectedCount = 25;

   typedef struct packed {
      logic [31:0]          word;
      logic                 last;
      logic                 fixed;
      cpsw_pkg::result_type want;
   } directed_row_type;

   localparam cpsw_pkg::result_type Unchecked = '0;

   // fixed rows run under the reset watch offset of zero
   localparam directed_row_type DirectedRows [DirectedCount] = '{
      '{32'h0000_0000, 1'b0, 1'b1,
        '{cpsw_pkg::KIND_PAD, 2'd0, 7'd0, 16'd0, 14'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          32'd0, 18'd0}},
      '{32'h8000_0000, 1'b0, 1'b1,
        '{cpsw_pkg::KIND_PAD, 2'd2, 7'd0, 16'd0, 14'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          32'd0, 18'd0}},
      '{32'hBFFF_FFFF, 1'b0, 1'b1,
        '{cpsw_pkg::KIND_PAD, 2'd2, 7'd0, 16'd0, 14'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          32'd0, 18'd0}},
      '{32'h0001_0578, 1'b0, 1'b1,
        '{cpsw_pkg::KIND_REG_HDR, 2'd0, 7'd0, 16'd0, 14'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          32'd0, 18'd0}},
      '{32'h0000_0000, 1'b0, 1'b1,
        '{cpsw_pkg::KIND_REG_PAY, 2'd0, 7'd0, 16'h0578, 14'd0, 1'b1, 1'b1, 1'b0, 1'b0,
          1'b0, 32'd0, 18'd0}},
      '{32'hFFFF_FFFF, 1'b0, 1'b1,
        '{cpsw_pkg::KIND_REG_PAY, 2'd0, 7'd0, 16'h0579, 14'd1, 1'b0, 1'b1, 1'b0, 1'b0,
          1'b0, 32'd0, 18'd0}},
      '{32'h4000_01DC, 1'b0, 1'b1,
        '{cpsw_pkg::KIND_REG_HDR, 2'd1, 7'd0, 16'd0, 14'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          32'd0, 18'd0}},
      '{32'hE000_0000, 1'b0, 1'b1,
        '{cpsw_pkg::KIND_REG_PAY, 2'd1, 7'd0, 16'h01DC, 14'd0, 1'b1, 1'b0, 1'b1, 1'b0,
          1'b0, 32'd0, 18'd0}},
      '{32'h7FFF_7FFF, 1'b0, 1'b0, Unchecked},
      '{32'h1234_5678, 1'b0, 1'b0, Unchecked},
      '{32'h0000_0000, 1'b1, 1'b0, Unchecked},
      '{32'hC000_4000, 1'b0, 1'b1,
        '{cpsw_pkg::KIND_CMD_HDR, 2'd3, 7'h40, 16'd0, 14'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
          32'd0, 18'd0}},
      '{32'h2000_0000, 1'b0, 1'b1,
        '{cpsw_pkg::KIND_CMD_PAY, 2'd3, 7'h40, 16'd0, 14'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
          32'd0, 18'd0}},
      '{32'hC001_3F00, 1'b0, 1'b0, Unchecked},
      '{32'h8765_4320, 1'b0, 1'b0, Unchecked},
      '{32'h0003_FFFF, 1'b0, 1'b1,
        '{cpsw_pkg::KIND_CMD_PAY, 2'd3, 7'h3F, 16'd0, 14'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
          32'h8765_4320, 18'h3FFFF}},
      '{32'hC000_3F00, 1'b0, 1'b0, Unchecked},
      '{32'h0000_1000, 1'b0, 1'b0, Unchecked},
      '{32'hC002_3F00, 1'b0, 1'b0, Unchecked},
      '{32'h0000_0000, 1'b0, 1'b0, Unchecked},
      '{32'h0000_0010, 1'b0, 1'b0, Unchecked},
      '{32'h0000_0000, 1'b0, 1'b0, Unchecked},
      '{32'hC001_BFFF, 1'b0, 1'b0, Unchecked},
      '{32'h1111_1111, 1'b0, 1'b0, Unchecked},
      '{32'h0004_0000, 1'b1, 1'b1,
        '{cpsw_pkg::KIND_CMD_PAY, 2'd3, 7'h3F, 16'd0, 14'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          32'd0, 18'd0}}
   };

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [28:0] csr_write_data;

   cpsw_req_if req_ch ();
   cpsw_rsp_if rsp_ch ();

   command_packet_stream_watch dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // predictor state
   logic [28:0] watch_model;
   logic [14:0] pkt_words_left;
   logic [13:0] pkt_position;
   logic [1:0]  pkt_type;
   logic [6:0]  pkt_opcode;
   logic [14:0] pkt_first_reg;
   logic        pkt_hit_seen;
   logic [31:0] pkt_held_addr;

   cpsw_pkg::result_type pending_classes [$];
   int unsigned mismatch_count = 0;
   int unsigned words_sent = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 21;
   int unsigned recv_idle_pct = 47;
   int unsigned hold_left = 0;
   bit          hold_request = 1'b0;

   function automatic void clear_packet_model();
      pkt_words_left = '0;
      pkt_position   = '0;
      pkt_type       = '0;
      pkt_opcode     = '0;
      pkt_first_reg  = '0;
      pkt_hit_seen   = 1'b0;
      pkt_held_addr  = '0;
   endfunction

   function automatic cpsw_pkg::result_type classify_word(logic [31:0] w, logic last);
      cpsw_pkg::result_type r;
      logic [15:0]          reg_num;
      logic                 match;
      r = '0;
      if (pkt_words_left == 0) begin
         r.packet_type = w[31:30];
         if (w != 0 && w[31:30] != cpsw_pkg::PKT_TYPE2) begin
            pkt_words_left = {1'b0, w[29:16]} + 15'd1;
            pkt_position   = '0;
            pkt_type       = w[31:30];
            pkt_hit_seen   = 1'b0;
            pkt_held_addr  = '0;
            if (w[31:30] == cpsw_pkg::PKT_TYPE3) begin
               pkt_opcode         = w[14:8];
               pkt_first_reg      = '0;
               r.word_kind        = cpsw_pkg::KIND_CMD_HDR;
               r.command_opcode   = w[14:8];
               r.interrupt_header = (w[14:8] == cpsw_pkg::OPC_INTERRUPT);
            end else begin
               pkt_first_reg = w[14:0];
               pkt_opcode    = '0;
               r.word_kind   = cpsw_pkg::KIND_REG_HDR;
            end
         end
      end else begin
         match           = (w[28:0] == watch_model);
         r.packet_type   = pkt_type;
         r.payload_index = pkt_position;
         if (pkt_type == cpsw_pkg::PKT_TYPE3) begin
            r.word_kind      = cpsw_pkg::KIND_CMD_PAY;
            r.command_opcode = pkt_opcode;
            if (match && !pkt_hit_seen) begin
               r.watch_hit  = 1'b1;
               pkt_hit_seen = 1'b1;
            end
            if (pkt_position == 0) begin
               pkt_held_addr = w;
            end else if (pkt_position == 1 && pkt_opcode == cpsw_pkg::OPC_INDIRECT) begin
               if (pkt_held_addr != 0 && w != 0 && w < cpsw_pkg::INDIRECT_SIZE_LIMIT) begin
                  r.indirect_valid   = 1'b1;
                  r.indirect_address = pkt_held_addr;
                  r.indirect_size    = w[17:0];
               end
            end
         end else begin
            reg_num                   = {1'b0, pkt_first_reg} + {2'b00, pkt_position};
            r.word_kind               = cpsw_pkg::KIND_REG_PAY;
            r.register_number         = reg_num;
            r.watch_hit               = match;
            r.scratch_write           = reg_num >= cpsw_pkg::REG_SCRATCH_FIRST &&
                                        reg_num <= cpsw_pkg::REG_SCRATCH_LAST;
            r.writeback_control_write = reg_num == cpsw_pkg::REG_WB_CTRL_LO ||
                                        reg_num == cpsw_pkg::REG_WB_CTRL_HI;
         end
         pkt_position   = pkt_position + 14'd1;
         pkt_words_left = pkt_words_left - 15'd1;
      end
      if (last)
         clear_packet_model();
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_result();
      cpsw_pkg::result_type want;
      if (pending_classes.size() == 0) begin
         $display("%0t: result with none expected, word_kind %0d", $time, rsp_ch.word_kind);
         mismatch_count++;
         return;
      end
      want = pending_classes.pop_front();
      check_field("word_kind", 32'(want.word_kind), 32'(rsp_ch.word_kind));
      check_field("packet_type", 32'(want.packet_type), 32'(rsp_ch.packet_type));
      check_field("command_opcode", 32'(want.command_opcode), 32'(rsp_ch.command_opcode));
      check_field("register_number", 32'(want.register_number),
                  32'(rsp_ch.register_number));
      check_field("payload_index", 32'(want.payload_index), 32'(rsp_ch.payload_index));
      check_field("watch_hit", 32'(want.watch_hit), 32'(rsp_ch.watch_hit));
      check_field("scratch_write", 32'(want.scratch_write), 32'(rsp_ch.scratch_write));
      check_field("writeback_control_write", 32'(want.writeback_control_write),
                  32'(rsp_ch.writeback_control_write));
      check_field("interrupt_header", 32'(want.interrupt_header),
                  32'(rsp_ch.interrupt_header));
      check_field("indirect_valid", 32'(want.indirect_valid), 32'(rsp_ch.indirect_valid));
      check_field("indirect_address", want.indirect_address, rsp_ch.indirect_address);
      check_field("indirect_size", 32'(want.indirect_size), 32'(rsp_ch.indirect_size));
   endtask

   // offers one word and returns at the edge of its transfer
   task automatic put_word(input logic [31:0] w, input logic last,
                           input logic use_fixed, input cpsw_pkg::result_type fixed);
      cpsw_pkg::result_type model;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.stream_word <= w;
      req_ch.buffer_end  <= last;
      do
         @(posedge clock);
      while (req_ch.ready !== 1'b1);
      model = classify_word(w, last);
      pending_classes.insert(pending_classes.size(), use_fixed ? fixed : model);
      words_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_classes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_watch(input logic [28:0] offset);
      csr_write_enable <= 1'b1;
      csr_write_data   <= offset;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      watch_model = offset;
   endtask

   function automatic logic [31:0] payload_word(logic [1:0] ptype, logic [6:0] opc, int idx);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (ptype == cpsw_pkg::PKT_TYPE3 && opc == cpsw_pkg::OPC_INDIRECT && idx == 1) begin
         case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'($urandom_range(1, 255));
            2: return cpsw_pkg::INDIRECT_SIZE_LIMIT - 32'd1;
            3: return cpsw_pkg::INDIRECT_SIZE_LIMIT;
            4: return $urandom;
            default: return 32'($urandom_range(1, cpsw_pkg::INDIRECT_SIZE_LIMIT - 1));
         endcase
      end
      if (roll < 15)
         return {3'($urandom), watch_model};
      if (roll < 25)
         return 32'd0;
      return $urandom;
   endfunction

   // one well-formed packet with random content, sometimes cut short by a buffer end, or a noise word
   task automatic send_packet();
      logic [1:0]  ptype;
      logic [13:0] count;
      logic [6:0]  opc;
      logic [14:0] base;
      logic [31:0] w;
      logic        end_on_final;
      int          len;
      int          cut;
      int unsigned roll;
      if ($urandom_range(0, 99) < 12) begin
         case ($urandom_range(0, 3))
            0: w = 32'd0;
            1: w = {cpsw_pkg::PKT_TYPE2, 30'($urandom)};
            default: w = $urandom;
         endcase
         put_word(w, $urandom_range(0, 7) == 0, 1'b0, Unchecked);
         return;
      end
      case ($urandom_range(0, 3))
         0: ptype = PKT_TYPE0;
         1: ptype = PKT_TYPE1;
         default: ptype = cpsw_pkg::PKT_TYPE3;
      endcase
      case ($urandom_range(0, 3))
         0: opc = cpsw_pkg::OPC_INTERRUPT;
         1: opc = cpsw_pkg::OPC_INDIRECT;
         default: opc = 7'($urandom);
      endcase
      roll = $urandom_range(0, 99);
      cut  = -2;
      if (roll < 4) begin
         // long count, cut short by the buffer end unless the count is below the cut point
         count = 14'($urandom);
         len   = int'(count) + 1;
         cut   = $urandom_range(0, 10) - 1;
      end else begin
         if (roll < 12)
            len = $urandom_range(9, 40);
         else if (ptype == cpsw_pkg::PKT_TYPE3 && opc == cpsw_pkg::OPC_INDIRECT)
            len = $urandom_range(1, 3);
         else
            len = $urandom_range(1, 8);
         count = 14'(len - 1);
         if ($urandom_range(0, 9) == 0)
            cut = $urandom_range(0, len) - 1;
      end
      end_on_final = ($urandom_range(0, 5) == 0);
      if (ptype == cpsw_pkg::PKT_TYPE3) begin
         w = {ptype, count, 1'($urandom), opc, 8'($urandom)};
      end else begin
         case ($urandom_range(0, 3))
            0: base = 15'h0570 + 15'($urandom_range(0, 15));
            1: base = 15'h01D8 + 15'($urandom_range(0, 7));
            2: base = 15'h7FF0 + 15'($urandom_range(0, 15));
            default: base = 15'($urandom);
         endcase
         w = {ptype, count, 1'($urandom), base};
      end
      put_word(w, cut == -1, 1'b0, Unchecked);
      if (cut == -1)
         return;
      for (int i = 0; i < len; i++) begin
         put_word(payload_word(ptype, opc, i),
                  (i == cut) || (cut == -2 && i == len - 1 && end_on_final),
                  1'b0, Unchecked);
         if (i == cut)
            return;
      end
   endtask

   task automatic send_random(input int unsigned n);
      int unsigned stop_at;
      stop_at = words_sent + n;
      while (words_sent < stop_at)
         send_packet();
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CycleLimit) begin
            $display("command_packet_stream_watch: mismatch");
            $finish;
         end
      end
   end

   // result side: checks each transfer and drives ready
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_result();
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HoldCycles;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      reset              <= 1'b1;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.stream_word <= '0;
      req_ch.buffer_end  <= 1'b0;
      watch_model = '0;
      clear_packet_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DirectedCount; i++)
         put_word(DirectedRows[i].word, DirectedRows[i].last,
                  DirectedRows[i].fixed, DirectedRows[i].want);
      drain();

      set_watch(29'h1FFF_FFFF);
      send_random(500);
      drain();

      // receiver holds off while the sender keeps offering
      set_watch(29'($urandom));
      send_idle_pct = 0;
      hold_request  = 1'b1;
      send_random(60);
      drain();

      send_idle_pct = 47;
      recv_idle_pct = 21;
      send_random(450);
      drain();

      set_watch(29'd0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(500);
      drain();

      if (mismatch_count == 0)
         $display("command_packet_stream_watch: match");
      else
         $display("command_packet_stream_watch: mismatch");
      $finish;
   end

endmodule

/* filelist.f */
rtl/cpsw_pkg.sv
rtl/cpsw_req_if.sv
rtl/cpsw_rsp_if.sv
rtl/cpsw_parser.sv
rtl/command_packet_stream_watch.sv
tb/sv/tb_command_packet_stream_watch.sv
